[hw/rtl/sha_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_pkg: shared types, constants and functions
// Round constants, initial hash values and the controller state encoding.
// ----------------------------------------------------------------------------
package sha_pkg;

	localparam int BlockWords = 16;
	localparam int WordWidth  = 32;
	localparam int WinAddrW   = 4;
	localparam int BufDepth   = 16;
	localparam logic [7:0] PadByte = 8'h80;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_ROUND,
		ST_FINAL,
		ST_PAD,
		ST_OUT
	} sha_state_t;

	function automatic logic [31:0] round_k(input logic [5:0] i);
		logic [31:0] k;
		unique case (i)
			6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
			6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
			6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
			6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
			6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
			6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
			6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
			6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
			6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
			6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
			6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
			6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
			6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
			6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
			6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
			6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
			6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
			6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
			6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
			6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
			6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
			6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
			6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
			default: k = 32'h0;
		endcase
		return k;
	endfunction

	function automatic logic [31:0] init_h(input logic [2:0] i);
		logic [31:0] h;
		unique case (i)
			3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
			3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
			3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
			3'd6: h = 32'h1f83d9ab; 3'd7: h = 32'h5be0cd19;
			default: h = 32'h0;
		endcase
		return h;
	endfunction

endpackage

[hw/rtl/sha_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module sha_ram #(
	parameter int Width = 32,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

[hw/rtl/sha256_message_hasher_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_message_hasher_top: streaming SHA-256 hasher
// Byte stream in, 256-bit digest out on each end-of-message transaction.
// ----------------------------------------------------------------------------
// channel | dir | payload
// s_axis  | in  | tdata[7:0] data_byte, tuser[0] byte_present, tlast end_of_message
// m_axis  | out | tdata[255:0] digest words 0..7, word 0 in the high bits of [63:0]
//
// The 64th byte of a block starts a compression with the input stalled: the 16
// block words load from the RAM into the schedule window, then 64 rounds, then
// one fold. An end mark adds a padding pass over the 16 block words before each
// padded compression; when the length does not fit after the 0x80, a second
// padded block follows, and an end mark on a 64th byte first has that full block
// compressed.
// Reset clears control, length and count and loads the chaining words with the initial hash values; RAM needs none.
// A digest waiting in the output register stalls the input side.
// ----------------------------------------------------------------------------
module sha256_message_hasher_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
	input  logic         s_axis_tuser,   // [0] byte_present
	input  logic         s_axis_tlast,   // end_of_message
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [255:0] m_axis_tdata    // [63:0] bits_255_192, [127:64] 191_128,
	                                     // [191:128] 127_64, [255:192] 63_0
);
	import sha_pkg::*;

	// The RAM holds the packed block as 16 words. The rounds run on a 16-word
	// register window loaded from it one word per cycle, so every schedule tap
	// (w[t-16], w[t-15], w[t-7], w[t-2]) sits at a fixed place.
	sha_state_t state_q, state_d;
	logic [31:0] h_q [8];
	logic [31:0] v_q [8];
	logic [31:0] w_q [16];
	logic [5:0]  cnt_q;       // bytes in block
	logic [63:0] len_q;
	logic [6:0]  rnd_q;       // round / load index
	logic        last_q;      // finalize pending after this block
	logic        pad_done_q;  // 0x80 already written
	logic        len_done_q;  // length words already written
	logic [23:0] part_q;      // bytes of a word in progress
	logic        out_v_q;
	logic [255:0] out_q;

	logic        ram_we;
	logic [3:0]  ram_waddr, ram_raddr;
	logic [31:0] ram_wdata, ram_rdata;

	sha_ram #(.Width(WordWidth), .Depth(BufDepth)) u_ram (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	wire acc = s_axis_tvalid && s_axis_tready;
	wire bp  = s_axis_tuser;
	assign s_axis_tready = (state_q == ST_IDLE) && !out_v_q;
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = out_q;

	// byte write into the word in progress
	logic [5:0]  cnt_n;
	logic [31:0] word_full;
	always_comb begin
		cnt_n = cnt_q + 6'd1;
		unique case (cnt_q[1:0])
			2'd0: word_full = {s_axis_tdata, 24'h0};
			2'd1: word_full = {part_q[23:16], s_axis_tdata, 16'h0};
			2'd2: word_full = {part_q[23:16], part_q[15:8], s_axis_tdata, 8'h0};
			default: word_full = {part_q, s_axis_tdata};
		endcase
	end

	// padding word for word index at pad state, n = bytes in block
	function automatic logic [31:0] pad_word(input logic [3:0] wi, input logic [5:0] n,
		input logic [23:0] part, input logic p80, input logic [63:0] len);
		logic [31:0] r;
		logic [3:0]  nw;
		r = 32'h0;
		nw = n[5:2];
		if (wi == 4'd14 && !(p80 && n > 6'd55)) r = len[63:32];
		else if (wi == 4'd15 && !(p80 && n > 6'd55)) r = len[31:0];
		else if (p80 && wi == nw) begin
			unique case (n[1:0])
				2'd0: r = {PadByte, 24'h0};
				2'd1: r = {part[23:16], PadByte, 16'h0};
				2'd2: r = {part[23:16], part[15:8], PadByte, 8'h0};
				default: r = {part, PadByte};
			endcase
		end
		return r;
	endfunction

	// round datapath
	logic [31:0] s0w, s1w, wnew, wi, t1, t2, bs0, bs1, ch, mj;
	always_comb begin
		s0w  = {w_q[1][6:0], w_q[1][31:7]} ^ {w_q[1][17:0], w_q[1][31:18]} ^ (w_q[1] >> 3);
		s1w  = {w_q[14][16:0], w_q[14][31:17]} ^ {w_q[14][18:0], w_q[14][31:19]}
		     ^ (w_q[14] >> 10);
		wnew = w_q[0] + s0w + w_q[9] + s1w;
		wi   = w_q[0];
		bs1  = {v_q[4][5:0], v_q[4][31:6]} ^ {v_q[4][10:0], v_q[4][31:11]}
		     ^ {v_q[4][24:0], v_q[4][31:25]};
		ch   = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		t1   = v_q[7] + bs1 + ch + round_k(rnd_q[5:0]) + wi;
		bs0  = {v_q[0][1:0], v_q[0][31:2]} ^ {v_q[0][12:0], v_q[0][31:13]}
		     ^ {v_q[0][21:0], v_q[0][31:22]};
		mj   = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t2   = bs0 + mj;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					if (bp && cnt_q == 6'd63) state_d = ST_LOAD;
					else if (s_axis_tlast) state_d = ST_PAD;
				end
			end
			ST_PAD:   if (rnd_q == 7'd15) state_d = ST_LOAD;
			ST_LOAD:  if (rnd_q == 7'd16) state_d = ST_ROUND;
			ST_ROUND: if (rnd_q == 7'd63) state_d = ST_FINAL;
			ST_FINAL: begin
				if (!last_q) state_d = ST_IDLE;
				else if (!len_done_q) state_d = ST_PAD;
				else state_d = ST_OUT;
			end
			ST_OUT:   state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// RAM port control; the first pad pass keeps the message words below the 0x80
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cnt_q[5:2];
		ram_wdata = word_full;
		ram_raddr = rnd_q[3:0];
		unique case (state_q)
			ST_IDLE: ram_we = acc && bp && (cnt_q[1:0] == 2'd3);
			ST_PAD: begin
				ram_we    = pad_done_q || (rnd_q[3:0] >= cnt_q[5:2]);
				ram_waddr = rnd_q[3:0];
				ram_wdata = pad_word(rnd_q[3:0], cnt_q, part_q, !pad_done_q, len_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0; len_q <= '0; rnd_q <= '0;
			last_q <= 1'b0; pad_done_q <= 1'b0; len_done_q <= 1'b0; out_v_q <= 1'b0;
			for (int i = 0; i < 8; i++) h_q[i] <= init_h(3'(i));
		end else begin
			state_q <= state_d;
			if (state_q == ST_OUT) out_v_q <= 1'b1;
			else if (out_v_q && m_axis_tready) out_v_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					rnd_q <= '0;
					if (acc) begin
						last_q <= s_axis_tlast;
						pad_done_q <= 1'b0;
						len_done_q <= 1'b0;
						if (bp) begin
							cnt_q <= cnt_n;
							len_q <= len_q + 64'd8;
							part_q <= word_full[31:8];
						end
					end
				end
				ST_PAD: begin
					rnd_q <= (rnd_q == 7'd15) ? 7'd0 : rnd_q + 7'd1;
					if (rnd_q == 7'd15) begin
						pad_done_q <= 1'b1;
						// no room for the length after the 0x80: one more block
						len_done_q <= pad_done_q || (cnt_q <= 6'd55);
					end
				end
				ST_LOAD: begin
					// registered read: word rnd-1 arrives now
					if (rnd_q != 7'd0) begin
						for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
						w_q[15] <= ram_rdata;
					end
					for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
					rnd_q <= (rnd_q == 7'd16) ? 7'd0 : rnd_q + 7'd1;
				end
				ST_ROUND: begin
					for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
					w_q[15] <= wnew;
					v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
					v_q[4] <= v_q[3] + t1;
					v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
					v_q[0] <= t1 + t2;
					rnd_q <= rnd_q + 7'd1;
				end
				ST_FINAL: begin
					rnd_q <= '0;
					for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
				end
				ST_OUT: begin
					for (int i = 0; i < 4; i++)
						out_q[64*i +: 64] <= {h_q[2*i], h_q[2*i+1]};
					for (int i = 0; i < 8; i++) h_q[i] <= init_h(3'(i));
					cnt_q <= '0; len_q <= '0; last_q <= 1'b0;
					pad_done_q <= 1'b0; len_done_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end
endmodule

[hw/rtl/sha_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_checker: port-level checks for the hasher
// Watches the stream ports and flags handshake and control slips.
// ----------------------------------------------------------------------------
module sha_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [255:0] m_axis_tdata
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("digest dropped while stalled");
	a_block: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready)
		else $error("input open while digest pending");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(!s_axis_tready))
		else $error("digest without compression");
endmodule

bind sha256_message_hasher_top sha_checker u_sha_checker (.*);
